@@ hw/rtl/websocket_frame_deframer_defines.svh @@
// Assertion macros for the WebSocket frame deframer.
// Taken in by the files that carry concurrent checks; no other dependencies.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define WSD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/wsd_pkg.sv @@
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; used by wsd_parser, wsd_skid and websocket_frame_deframer.
`timescale 1ns / 1ps

package wsd_pkg;

	// Default number of length bits kept from an extended length
	localparam int LENGTH_BITS_DEF = 31;

	// Widths of the result fields
	localparam int BYTE_W      = 8;
	localparam int OPCODE_W    = 4;
	localparam int FRAME_LEN_W = 31;

	// Output tdata: out_byte, frame_opcode, final_flag, frame_length, zero pad
	localparam int RES_DATA_W = BYTE_W + OPCODE_W + 1 + FRAME_LEN_W;
	localparam int TDATA_W    = ((RES_DATA_W + 7) / 8) * 8;
	localparam int TPAD_W     = TDATA_W - RES_DATA_W;

	// Short-length codes that announce an extended length
	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	// One result item
	typedef struct packed {
		logic [BYTE_W-1:0]      out_byte;
		logic                   byte_valid;
		logic [OPCODE_W-1:0]    frame_opcode;
		logic                   final_flag;
		logic [FRAME_LEN_W-1:0] frame_length;
		logic                   last_of_frame;
	} res_t;

endpackage

@@ hw/rtl/wsd_parser.sv @@
// Frame parser: header, extended length, masking key and payload unmasking.
// Depends on wsd_pkg for the result type and length codes.
`timescale 1ns / 1ps

module wsd_parser #(
	parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          discard,
	input  logic          in_valid,   // byte transfer accepted this cycle
	input  logic [7:0]    in_byte,
	output logic          res_valid,
	output wsd_pkg::res_t res
);

	typedef enum logic [2:0] {
		PH_HDR0  = 3'd0,
		PH_HDR1  = 3'd1,
		PH_EXT16 = 3'd2,
		PH_EXT64 = 3'd3,
		PH_KEY   = 3'd4,
		PH_DATA  = 3'd5
	} phase_t;

	phase_t                 phase_q, phase_n;
	logic                   fin_q, fin_n;
	logic [3:0]             opcode_q, opcode_n;
	logic                   masked_q, masked_n;
	logic [2:0]             cnt_q, cnt_n;
	logic [LENGTH_BITS-1:0] len_q, len_n;
	logic [31:0]            key_q, key_n;
	logic [LENGTH_BITS-1:0] rem_q, rem_n;
	logic [1:0]             kidx_q, kidx_n;

	logic       do_after;
	logic       do_begin;
	logic       res_v;
	logic [7:0] kb;
	logic       last;

	// Next state and result for one byte
	always_comb begin
		phase_n  = phase_q;
		fin_n    = fin_q;
		opcode_n = opcode_q;
		masked_n = masked_q;
		cnt_n    = cnt_q;
		len_n    = len_q;
		key_n    = key_q;
		rem_n    = rem_q;
		kidx_n   = kidx_q;
		do_after = 1'b0;
		do_begin = 1'b0;
		res_v    = 1'b0;
		kb       = '0;
		last     = 1'b0;
		res.out_byte      = '0;
		res.byte_valid    = 1'b0;
		res.last_of_frame = 1'b0;

		case (phase_q)
			PH_HDR1: begin
				masked_n = in_byte[7];
				len_n    = '0;
				cnt_n    = '0;
				if (in_byte[6:0] == wsd_pkg::LEN7_EXT16) begin
					phase_n = PH_EXT16;
				end else if (in_byte[6:0] == wsd_pkg::LEN7_EXT64) begin
					phase_n = PH_EXT64;
				end else begin
					len_n    = LENGTH_BITS'(in_byte[6:0]);
					do_after = 1'b1;
				end
			end
			PH_EXT16: begin
				len_n = {len_q[LENGTH_BITS-9:0], in_byte};
				cnt_n = cnt_q + 3'd1;
				if (cnt_n >= 3'd2) begin
					do_after = 1'b1;
				end
			end
			PH_EXT64: begin
				// eight bytes: the count wraps to zero on the last one
				len_n = {len_q[LENGTH_BITS-9:0], in_byte};
				cnt_n = cnt_q + 3'd1;
				if (cnt_n == 3'd0) begin
					do_after = 1'b1;
				end
			end
			PH_KEY: begin
				key_n = {key_q[23:0], in_byte};
				cnt_n = cnt_q + 3'd1;
				if (cnt_n >= 3'd4) begin
					do_begin = 1'b1;
				end
			end
			PH_DATA: begin
				// first key byte sits in the top bits
				if (masked_q) begin
					kb = key_q[{~kidx_q, 3'b000} +: 8];
				end
				kidx_n = kidx_q + 2'd1;
				if (rem_q != '0) begin
					rem_n = rem_q - LENGTH_BITS'(1);
				end
				last = (rem_n == '0);
				if (last) begin
					phase_n = PH_HDR0;
				end
				if (discard) begin
					res_v             = last;
					res.last_of_frame = last;
				end else begin
					res_v             = 1'b1;
					res.out_byte      = in_byte ^ kb;
					res.byte_valid    = 1'b1;
					res.last_of_frame = last;
				end
			end
			default: begin
				fin_n    = in_byte[7];
				opcode_n = in_byte[3:0];
				phase_n  = PH_HDR1;
			end
		endcase

		// Length complete: collect the key or go straight to the payload
		if (do_after) begin
			if (masked_n) begin
				key_n   = '0;
				cnt_n   = '0;
				phase_n = PH_KEY;
			end else begin
				do_begin = 1'b1;
			end
		end

		// Payload start; an empty frame ends here with one result
		if (do_begin) begin
			if (len_n == '0) begin
				res_v             = 1'b1;
				res.last_of_frame = 1'b1;
				phase_n           = PH_HDR0;
			end else begin
				rem_n   = len_n;
				kidx_n  = '0;
				phase_n = PH_DATA;
			end
		end

		res.frame_opcode = opcode_q;
		res.final_flag   = fin_q;
		res.frame_length = wsd_pkg::FRAME_LEN_W'(len_n);
		res_valid        = in_valid & res_v;
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			fin_q    <= 1'b0;
			opcode_q <= '0;
			masked_q <= 1'b0;
			cnt_q    <= '0;
			len_q    <= '0;
			key_q    <= '0;
			rem_q    <= '0;
			kidx_q   <= '0;
		end else if (in_valid) begin
			phase_q  <= phase_n;
			fin_q    <= fin_n;
			opcode_q <= opcode_n;
			masked_q <= masked_n;
			cnt_q    <= cnt_n;
			len_q    <= len_n;
			key_q    <= key_n;
			rem_q    <= rem_n;
			kidx_q   <= kidx_n;
		end
	end

endmodule

@@ hw/rtl/wsd_skid.sv @@
// Output register with a skid stage, so input transfers continue while a
// result waits. Depends on wsd_pkg for the result type.
`timescale 1ns / 1ps

module wsd_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  wsd_pkg::res_t in_res,
	output logic          in_ready,
	output logic          out_valid,
	output wsd_pkg::res_t out_res,
	input  logic          out_ready
);

	logic          out_v_q;
	logic          skid_v_q;
	wsd_pkg::res_t out_q;
	wsd_pkg::res_t skid_q;

	assign in_ready  = !skid_v_q;
	assign out_valid = out_v_q;
	assign out_res   = out_q;

	// Control: output slot refills from the skid stage first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_ready || !out_v_q) begin
			out_v_q  <= skid_v_q | in_valid;
			skid_v_q <= 1'b0;
		end else if (in_valid) begin
			skid_v_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (out_ready || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : in_res;
		end else if (in_valid) begin
			skid_q <= in_res;
		end
	end

endmodule

@@ hw/rtl/websocket_frame_deframer.sv @@
// WebSocket frame deframer. One stream byte is taken per transfer, and a
// transfer can be accepted every cycle. Each byte's result, if it has one, is
// registered at the edge that takes the byte. If the output register is free,
// it is offered on the master side from the next cycle; else it waits in a
// one-entry skid stage. s_tready falls only when both hold a result that has
// not been taken. Header, length and key bytes give no result, except that an
// empty frame gives one result on the last of those bytes. Payload bytes come
// out unmasked with the frame fields; with discard_payload set only the end of
// each frame is reported. No clearing pass after reset. Depends on wsd_pkg,
// wsd_parser, wsd_skid and the assertion macro header.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_defines.svh"

module websocket_frame_deframer #(
	parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration: discard_payload in bit 0
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_data,
	// slave side
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
	// master side
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [7:0] out_byte, [11:8] frame_opcode, [12] final_flag,
	// [43:13] frame_length, rest zero
	output logic [wsd_pkg::TDATA_W-1:0] m_tdata,
	output logic                        m_tlast,   // last_of_frame
	output logic                        m_tuser    // byte_valid
);

	logic          discard_q;
	logic          s_xfer;
	logic          res_valid;
	wsd_pkg::res_t res;
	wsd_pkg::res_t out_res;

	// Configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			discard_q <= 1'b0;
		end else if (cfg_valid) begin
			discard_q <= cfg_data;
		end
	end

	assign s_xfer = s_tvalid & s_tready;

	wsd_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.discard  (discard_q),
		.in_valid (s_xfer),
		.in_byte  (s_tdata),
		.res_valid(res_valid),
		.res      (res)
	);

	wsd_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_res   (res),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_res  (out_res),
		.out_ready(m_tready)
	);

	// Pack the result onto the master side
	assign m_tdata = {{wsd_pkg::TPAD_W{1'b0}}, out_res.frame_length, out_res.final_flag,
		out_res.frame_opcode, out_res.out_byte};
	assign m_tlast = out_res.last_of_frame;
	assign m_tuser = out_res.byte_valid;

	// Checks
	`WSD_ASSERT_IMPLIES(a_stall_needs_output, clk, arst_n, !s_tready, m_tvalid,
		"input stalled with no result pending")
	`WSD_ASSERT_IMPLIES(a_empty_is_last, clk, arst_n, m_tvalid && !m_tuser,
		m_tlast && (m_tdata[7:0] == 8'd0), "result without a byte is not a clean frame end")
	`WSD_ASSERT_IMPLIES(a_discard_no_bytes, clk, arst_n, discard_q && s_xfer,
		!(res_valid && res.byte_valid), "payload byte produced in discard mode")
	`WSD_ASSERT_NEXT(a_result_offered, clk, arst_n, res_valid, m_tvalid,
		"result taken in but not offered")

endmodule
